[src/circle_span_rasterizer_top_defines.svh]
// ----------------------------------------------------------------------------
// circle_span_rasterizer_top_defines
// assertion macros shared by the rasterizer rtl
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SPAN_RASTERIZER_TOP_DEFINES_SVH
`define CIRCLE_SPAN_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/csr_pkg.sv]
// ----------------------------------------------------------------------------
// csr_pkg
// widths, register codes and types of the circle span rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package csr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int OUT_BITS      = COORD_BITS + 2;
	localparam int RADIUS_BITS   = COORD_BITS - 1;
	localparam int STEP_BITS     = COORD_BITS;
	localparam int RAD_SQ_BITS   = 2 * RADIUS_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = COORD_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FILL_ENABLE = 2'd3;

	// sideband that rides along the square root stages
	typedef struct packed {
		logic                       invalid;
		logic signed [OUT_BITS-1:0] base_x;
		logic signed [OUT_BITS-1:0] base_y;
	} side_t;

endpackage

`default_nettype wire

[src/circle_span_rasterizer_top.sv]
// pipeline: 3 + radius bits + 1 register stages from item accept to result valid
// throughput: one item per cycle while the result is not stalled; the square root resolves one bit per stage
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset: valid bits and config registers clear asynchronously on arst_n low
// ----------------------------------------------------------------------------
// circle_span_rasterizer_top
// pipelined circle step: half extent by integer square root, span endpoints
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_span_rasterizer_top_defines.svh"

module circle_span_rasterizer_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output      logic                                   cfg_ready,
	input  wire logic [csr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [csr_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic                                   step_valid,
	output      logic                                   step_ready,
	input  wire logic [csr_pkg::STEP_BITS-1:0]          step_offset,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    column_x,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    column_y_top,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    column_y_bottom,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    row_y,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    row_x_left,
	output      logic signed [csr_pkg::OUT_BITS-1:0]    row_x_right,
	output      logic                                   fill_spans,
	output      logic                                   offset_invalid
);
	import csr_pkg::*;

	localparam int NR = RADIUS_BITS;

	// configuration registers
	logic [COORD_BITS-1:0]  center_x_q;
	logic [COORD_BITS-1:0]  center_y_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic                   fill_enable_q;

	logic adv;

	// stage 1: offset magnitude, range check, base coordinates
	logic                 vld_s1;
	logic [NR-1:0]        abs_off_s1;
	side_t                side_s1;
	// stage 2: squares
	logic                 vld_s2;
	logic [RAD_SQ_BITS-1:0] sq_r_s2;
	logic [RAD_SQ_BITS-1:0] sq_off_s2;
	side_t                side_s2;
	// stage 3: radicand
	logic                 vld_s3;
	logic [RAD_SQ_BITS-1:0] n_s3;
	side_t                side_s3;
	// square root stages, one result bit each
	logic                 rt_vld_s  [NR];
	logic [NR-1:0]        rt_root_s [NR];
	logic [NR+1:0]        rt_rem_s  [NR];
	logic [RAD_SQ_BITS-1:0] rt_n_s  [NR];
	side_t                rt_side_s [NR];
	// output register
	logic                   out_valid_q;
	logic signed [OUT_BITS-1:0] column_x_q, column_y_top_q, column_y_bottom_q;
	logic signed [OUT_BITS-1:0] row_y_q, row_x_left_q, row_x_right_q;
	logic                   fill_spans_q, offset_invalid_q;

	assign cfg_ready  = 1'b1;
	assign adv        = !out_valid_q || out_ready;
	assign step_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			radius_q      <= '0;
			fill_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X:    center_x_q    <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[COORD_BITS-1:0];
				REG_RADIUS:      radius_q      <= cfg_data[RADIUS_BITS-1:0];
				REG_FILL_ENABLE: fill_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1
	logic                 s1_ge;
	logic [STEP_BITS-1:0] s1_diff;
	side_t                s1_side;

	always_comb begin
		s1_ge   = step_offset >= STEP_BITS'(radius_q);
		s1_diff = s1_ge ? (step_offset - STEP_BITS'(radius_q))
		                : (STEP_BITS'(radius_q) - step_offset);
		s1_side.invalid = step_offset > {radius_q, 1'b0};
		s1_side.base_x  = OUT_BITS'(center_x_q) - OUT_BITS'(radius_q)
		                  + OUT_BITS'(step_offset);
		s1_side.base_y  = OUT_BITS'(center_y_q) - OUT_BITS'(radius_q)
		                  + OUT_BITS'(step_offset);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= step_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// magnitude only matters on a valid step, where it stays within the radius
			abs_off_s1 <= s1_diff[NR-1:0];
			side_s1    <= s1_side;
			sq_r_s2    <= RAD_SQ_BITS'(radius_q) * RAD_SQ_BITS'(radius_q);
			sq_off_s2  <= RAD_SQ_BITS'(abs_off_s1) * RAD_SQ_BITS'(abs_off_s1);
			side_s2    <= side_s1;
			n_s3       <= sq_r_s2 - sq_off_s2;
			side_s3    <= side_s2;
		end
	end

	// ---------------- square root, restoring digit recurrence
	for (genvar k = 0; k < NR; k++) begin : g_rt
		logic                 vin;
		logic [NR-1:0]        root_in;
		logic [NR+1:0]        rem_in;
		logic [RAD_SQ_BITS-1:0] n_in;
		side_t                side_in;
		logic [NR+1:0]        rem_sh;
		logic [NR+1:0]        trial;
		logic                 take;

		if (k == 0) begin : g_first
			assign vin     = vld_s3;
			assign root_in = '0;
			assign rem_in  = '0;
			assign n_in    = n_s3;
			assign side_in = side_s3;
		end else begin : g_next
			assign vin     = rt_vld_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign rem_in  = rt_rem_s[k-1];
			assign n_in    = rt_n_s[k-1];
			assign side_in = rt_side_s[k-1];
		end

		assign rem_sh = {rem_in[NR-1:0], n_in[2*(NR-1-k)+1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (adv) begin
				rt_vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_root_s[k] <= {root_in[NR-2:0], take};
				rt_rem_s[k]  <= take ? (rem_sh - trial) : rem_sh;
				rt_n_s[k]    <= n_in;
				rt_side_s[k] <= side_in;
			end
		end
	end

	// ---------------- rounding and endpoints
	logic [NR-1:0]   fin_root;
	logic [NR+1:0]   fin_rem;
	side_t           fin_side;
	logic            fin_up;
	logic [NR:0]     fin_h;
	logic signed [OUT_BITS-1:0] fin_hx;

	always_comb begin
		fin_root = rt_root_s[NR-1];
		fin_rem  = rt_rem_s[NR-1];
		fin_side = rt_side_s[NR-1];
		// n - s*s > s means sqrt(n) lies above s + 1/2
		fin_up   = fin_rem > (NR+2)'(fin_root);
		fin_h    = (NR+1)'(fin_root) + (NR+1)'(fin_up);
		fin_hx   = OUT_BITS'(fin_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rt_vld_s[NR-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin_side.invalid) begin
				column_x_q        <= '0;
				column_y_top_q    <= '0;
				column_y_bottom_q <= '0;
				row_y_q           <= '0;
				row_x_left_q      <= '0;
				row_x_right_q     <= '0;
				fill_spans_q      <= 1'b0;
				offset_invalid_q  <= 1'b1;
			end else begin
				column_x_q        <= fin_side.base_x;
				column_y_top_q    <= OUT_BITS'(center_y_q) - fin_hx;
				column_y_bottom_q <= OUT_BITS'(center_y_q) + fin_hx;
				row_y_q           <= fin_side.base_y;
				row_x_left_q      <= OUT_BITS'(center_x_q) - fin_hx;
				row_x_right_q     <= OUT_BITS'(center_x_q) + fin_hx;
				fill_spans_q      <= fill_enable_q;
				offset_invalid_q  <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign column_x        = column_x_q;
	assign column_y_top    = column_y_top_q;
	assign column_y_bottom = column_y_bottom_q;
	assign row_y           = row_y_q;
	assign row_x_left      = row_x_left_q;
	assign row_x_right     = row_x_right_q;
	assign fill_spans      = fill_spans_q;
	assign offset_invalid  = offset_invalid_q;

	// ---------------- checks
	`CSR_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !step_ready,
		"input taken while result stalled")
	`CSR_ASSERT_IMPL(a_invalid_zeroed, out_valid && offset_invalid,
		!fill_spans && column_x == '0 && row_x_right == '0,
		"invalid step carries nonzero result")
	`CSR_ASSERT_IMPL(a_spans_match, out_valid && !offset_invalid,
		(column_y_bottom - column_y_top) == (row_x_right - row_x_left),
		"column and row spans differ")

endmodule

`default_nettype wire

[verif/circle_span_rasterizer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_span_rasterizer_top_tb
// drives step offsets and register writes into the rasterizer, predicts each
// span result with an exact integer square root and checks every result in
// order, under random sender gaps, receiver stalls and a long output hold-off
// ----------------------------------------------------------------------------
module circle_span_rasterizer_top_tb;
	import csr_pkg::*;

	typedef logic signed [OUT_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t column_x;
		coord_t column_y_top;
		coord_t column_y_bottom;
		coord_t row_y;
		coord_t row_x_left;
		coord_t row_x_right;
		logic   fill_spans;
		logic   offset_invalid;
	} span_t;

	class span_scoreboard;
		logic [COORD_BITS-1:0]  cx;
		logic [COORD_BITS-1:0]  cy;
		logic [RADIUS_BITS-1:0] rad;
		logic                   fill;
		span_t                  expected_spans[$];
		int                     errors;

		function new();
			cx = '0;
			cy = '0;
			rad = '0;
			fill = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_CENTER_X: cx = data[COORD_BITS-1:0];
				REG_CENTER_Y: cy = data[COORD_BITS-1:0];
				REG_RADIUS: rad = data[RADIUS_BITS-1:0];
				REG_FILL_ENABLE: fill = data[0];
				default: ;
			endcase
		endfunction

		// half extent is sqrt(r*r - (d-r)^2) rounded half up
		function void note_step(logic [STEP_BITS-1:0] d);
			span_t e;
			int dv, rv, cxv, cyv, off, n, s, b;
			dv = d;
			rv = rad;
			cxv = cx;
			cyv = cy;
			e = '0;
			if (dv > 2 * rv) begin
				e.offset_invalid = 1'b1;
			end else begin
				off = dv - rv;
				n = rv * rv - off * off;
				s = 0;
				for (b = 1 << (RADIUS_BITS - 1); b > 0; b = b >> 1)
					if ((s + b) * (s + b) <= n)
						s = s + b;
				if (n > s * s + s)
					s = s + 1;
				e.column_x = coord_t'(cxv - rv + dv);
				e.column_y_top = coord_t'(cyv - s);
				e.column_y_bottom = coord_t'(cyv + s);
				e.row_y = coord_t'(cyv - rv + dv);
				e.row_x_left = coord_t'(cxv - s);
				e.row_x_right = coord_t'(cxv + s);
				e.fill_spans = fill;
			end
			expected_spans.push_back(e);
		endfunction

		function void compare_field(string name, logic signed [31:0] exp_v,
			logic signed [31:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(span_t got);
			span_t e;
			if (expected_spans.size() == 0) begin
				$error("result with no step outstanding");
				errors++;
				return;
			end
			e = expected_spans.pop_front();
			compare_field("column_x", e.column_x, got.column_x);
			compare_field("column_y_top", e.column_y_top, got.column_y_top);
			compare_field("column_y_bottom", e.column_y_bottom, got.column_y_bottom);
			compare_field("row_y", e.row_y, got.row_y);
			compare_field("row_x_left", e.row_x_left, got.row_x_left);
			compare_field("row_x_right", e.row_x_right, got.row_x_right);
			compare_field("fill_spans", e.fill_spans, got.fill_spans);
			compare_field("offset_invalid", e.offset_invalid, got.offset_invalid);
		endfunction

		function int pending();
			return expected_spans.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     step_valid = 1'b0;
	logic                     step_ready;
	logic [STEP_BITS-1:0]     step_offset = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	coord_t                   column_x;
	coord_t                   column_y_top;
	coord_t                   column_y_bottom;
	coord_t                   row_y;
	coord_t                   row_x_left;
	coord_t                   row_x_right;
	logic                     fill_spans;
	logic                     offset_invalid;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	span_scoreboard sb = new();

	circle_span_rasterizer_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.step_valid      (step_valid),
		.step_ready      (step_ready),
		.step_offset     (step_offset),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.column_x        (column_x),
		.column_y_top    (column_y_top),
		.column_y_bottom (column_y_bottom),
		.row_y           (row_y),
		.row_x_left      (row_x_left),
		.row_x_right     (row_x_right),
		.fill_spans      (fill_spans),
		.offset_invalid  (offset_invalid)
	);

	always #4 clk = ~clk;

	// accepted items on all three channels
	always @(posedge clk) begin
		span_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (step_valid && step_ready)
				sb.note_step(step_offset);
			if (out_valid && out_ready) begin
				got.column_x = column_x;
				got.column_y_top = column_y_top;
				got.column_y_bottom = column_y_bottom;
				got.row_y = row_y;
				got.row_x_left = row_x_left;
				got.row_x_right = row_x_right;
				got.fill_spans = fill_spans;
				got.offset_invalid = offset_invalid;
				sb.check_result(got);
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_step(input int d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			step_valid <= 1'b0;
			@(negedge clk);
		end
		step_valid <= 1'b1;
		step_offset <= STEP_BITS'(d);
		do @(posedge clk); while (!step_ready);
	endtask

	task automatic end_steps();
		@(negedge clk);
		step_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(data);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_circle(input int cx, input int cy, input int r, input int fill);
		program_reg(REG_CENTER_X, cx);
		program_reg(REG_CENTER_Y, cy);
		program_reg(REG_RADIUS, r);
		program_reg(REG_FILL_ENABLE, fill);
	endtask

	// random circle, extremes now and then, spare data bits random
	task automatic random_circle();
		int cx, cy, r;
		case ($urandom_range(9))
			0: r = 0;
			1: r = (1 << RADIUS_BITS) - 1;
			2, 3, 4: r = $urandom_range(1, 15);
			default: r = $urandom_range(0, (1 << RADIUS_BITS) - 1);
		endcase
		cx = ($urandom_range(7) == 0) ? (($urandom_range(1) != 0) ? 4095 : 0)
			: $urandom_range(0, 4095);
		cy = ($urandom_range(7) == 0) ? (($urandom_range(1) != 0) ? 4095 : 0)
			: $urandom_range(0, 4095);
		setup_circle(cx, cy, ($urandom_range(1) << RADIUS_BITS) | r, $urandom_range(0, 4095));
	endtask

	task automatic random_steps(input int count);
		int k, limit;
		for (k = 0; k < count; k++) begin
			limit = 2 * int'(sb.rad);
			if ($urandom_range(99) < 85)
				send_step($urandom_range(0, limit));
			else
				send_step($urandom_range(0, (1 << STEP_BITS) - 1));
		end
		end_steps();
		wait_drained();
	endtask

	initial begin
		int p, k;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// registers at reset: zero radius at the origin
		send_step(0);
		send_step(1);
		end_steps();
		wait_drained();

		// small filled circle, every offset plus two beyond
		setup_circle(100, 200, 5, 1);
		for (k = 0; k <= 11; k++)
			send_step(k);
		send_step(12'hfff);
		end_steps();
		wait_drained();

		// zero radius, outline; spare fill bits set
		setup_circle(37, 4000, 0, 12'hffe);
		send_step(0);
		send_step(1);
		end_steps();
		wait_drained();

		// largest circle at the top corner, radius written with its spare bit set
		setup_circle(4095, 4095, 12'hfff, 1);
		send_step(0);
		send_step(2047);
		send_step(4094);
		send_step(4095);
		send_step(1);
		end_steps();
		wait_drained();

		// largest circle at the origin reaches negative coordinates
		setup_circle(0, 0, 2047, 0);
		send_step(0);
		send_step(2047);
		send_step(4094);
		end_steps();
		wait_drained();

		// idling phases: none, sender gaps, receiver stalls, both
		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			random_circle();
			random_steps(90);
		end

		// long output hold-off while steps keep coming, so the input backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		setup_circle($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(1000, 2047), 1);
		@(posedge clk);
		hold_request = 120;
		random_steps(60);

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
